### rtl/nsh_pkg.sv
package nsh_pkg;

    localparam int MAX_MASK_DIM    = 128;
    localparam int TEXEL_COUNT     = 16384;
    localparam int COORD_FRAC_BITS = 4;
    localparam int ADDR_W          = $clog2(TEXEL_COUNT);
    localparam int COL_W           = $clog2(MAX_MASK_DIM);
    localparam int Q_BITS          = 7;
    localparam int DEN_W           = 15;
    localparam int NUM_W           = DEN_W + Q_BITS;
    localparam int MID_DEPTH       = 4;
    localparam int OUT_DEPTH       = 16;
    localparam int HALF_PIX        = (1 << COORD_FRAC_BITS) >> 1;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [1:0] ST_SAMPLED = 2'd0;
    localparam logic [1:0] ST_NO_MASK = 2'd1;
    localparam logic [1:0] ST_EDGES   = 2'd2;

    localparam logic [2:0] CFG_LEFT   = 3'd0;
    localparam logic [2:0] CFG_TOP    = 3'd1;
    localparam logic [2:0] CFG_RIGHT  = 3'd2;
    localparam logic [2:0] CFG_BOTTOM = 3'd3;
    localparam logic [2:0] CFG_MASK_W = 3'd4;
    localparam logic [2:0] CFG_MASK_H = 3'd5;
    localparam logic [2:0] CFG_CHAN   = 3'd6;
    localparam logic [2:0] CFG_THRESH = 3'd7;

    typedef struct packed {
        logic               opcode;
        logic [13:0]        texel_index;
        logic [31:0]        texel_rgba;
        logic signed [15:0] point_x;
        logic signed [15:0] point_y;
        logic signed [15:0] corner_x;
        logic signed [15:0] corner_y;
        logic [14:0]        sprite_width;
        logic [14:0]        sprite_height;
    } t_in;

    typedef struct packed {
        logic       hit;
        logic [1:0] status;
        logic [6:0] sample_column;
        logic [6:0] sample_row;
    } t_out;

    typedef struct packed {
        logic [7:0]        left_edge;
        logic [7:0]        top_edge;
        logic [7:0]        right_edge;
        logic [7:0]        bottom_edge;
        logic [7:0]        mask_width;
        logic [7:0]        mask_height;
        logic [1:0]        channel_select;
        logic signed [8:0] threshold;
    } t_cfg;

    typedef struct packed {
        logic              direct;
        logic [8:0]        val;
        logic [NUM_W-1:0]  num;
        logic [DEN_W-1:0]  den;
        logic [Q_BITS-1:0] quo;
    } t_axis;

    typedef struct packed {
        logic              opcode;
        logic [ADDR_W-1:0] addr;
        logic [31:0]       data;
        logic [1:0]        status;
        t_axis             ax;
        t_axis             ay;
    } t_job;

endpackage

### rtl/nsh_front.sv
module nsh_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  nsh_pkg::t_cfg i_cfg,
    input  logic          i_push,
    input  nsh_pkg::t_in  i_item,
    output logic          o_full,
    output logic          o_job_valid,
    output nsh_pkg::t_job o_job,
    input  logic          i_job_ready
);

    function automatic logic [14:0] clamp_c(input logic signed [15:0] pt,
                                            input logic signed [15:0] corner,
                                            input logic [14:0] size);
        logic signed [17:0] v;
        v = 18'(pt) - 18'(nsh_pkg::HALF_PIX) - 18'(corner);
        if (v < 0) begin
            return 15'd0;
        end else if (v > $signed({3'b000, size})) begin
            return size;
        end
        return v[14:0];
    endfunction

    function automatic nsh_pkg::t_axis map_axis(input logic [14:0] c,
                                                input logic [14:0] size,
                                                input logic [7:0] lo,
                                                input logic [7:0] hi,
                                                input logic [7:0] mdim);
        nsh_pkg::t_axis     a;
        logic [16:0]        lo_f;
        logic [16:0]        hi_f;
        logic signed [17:0] lim;
        logic [14:0]        t;
        logic [7:0]         md;
        logic [22:0]        prod;
        a      = '0;
        lo_f   = 17'(lo) << nsh_pkg::COORD_FRAC_BITS;
        hi_f   = 17'(hi) << nsh_pkg::COORD_FRAC_BITS;
        lim    = $signed({3'b000, size}) - $signed({1'b0, hi_f});
        t      = 15'((size - c) >> nsh_pkg::COORD_FRAC_BITS);
        md     = mdim - lo - hi;
        prod   = 23'(17'(c) - lo_f) * 23'(md);
        a.direct = 1'b1;
        if (17'(c) < lo_f) begin
            a.val = 9'(c >> nsh_pkg::COORD_FRAC_BITS);
        end else if ($signed({3'b000, c}) >= lim) begin
            a.val = (t > 15'(mdim)) ? 9'd0 : 9'(mdim) - 9'(t);
        end else if (9'(mdim) == 9'(lo) + 9'(hi)) begin
            a.val = 9'(lo);
        end else begin
            a.direct = 1'b0;
            a.val    = 9'(lo);
            a.num    = prod[nsh_pkg::NUM_W-1:0];
            a.den    = nsh_pkg::DEN_W'(17'(size) - lo_f - hi_f);
        end
        return a;
    endfunction

    logic          r1_v;
    nsh_pkg::t_in  r1_item;
    logic [14:0]   r1_cx;
    logic [14:0]   r1_cy;
    logic          r2_v;
    nsh_pkg::t_job r2_job;
    logic          adv1;
    logic          adv2;
    nsh_pkg::t_job n_job;

    assign adv2   = !r2_v || i_job_ready;
    assign adv1   = !r1_v || adv2;
    assign o_full = !adv1;

    always_comb begin
        n_job        = '0;
        n_job.opcode = r1_item.opcode;
        n_job.addr   = r1_item.texel_index;
        n_job.data   = r1_item.texel_rgba;
        if (i_cfg.mask_width == 8'd0 || i_cfg.mask_height == 8'd0) begin
            n_job.status = nsh_pkg::ST_NO_MASK;
        end else if (9'(i_cfg.left_edge) + 9'(i_cfg.right_edge) > 9'(i_cfg.mask_width) ||
                     9'(i_cfg.top_edge) + 9'(i_cfg.bottom_edge) > 9'(i_cfg.mask_height)) begin
            n_job.status = nsh_pkg::ST_EDGES;
        end else begin
            n_job.status = nsh_pkg::ST_SAMPLED;
        end
        n_job.ax = map_axis(r1_cx, r1_item.sprite_width, i_cfg.left_edge,
                            i_cfg.right_edge, i_cfg.mask_width);
        n_job.ay = map_axis(r1_cy, r1_item.sprite_height, i_cfg.top_edge,
                            i_cfg.bottom_edge, i_cfg.mask_height);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
        end else begin
            if (adv1) begin
                r1_v <= i_push;
            end
            if (adv2) begin
                r2_v <= r1_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r1_item <= i_item;
            r1_cx   <= clamp_c(i_item.point_x, i_item.corner_x, i_item.sprite_width);
            r1_cy   <= clamp_c(i_item.point_y, i_item.corner_y, i_item.sprite_height);
        end
        if (adv2) begin
            r2_job <= n_job;
        end
    end

    assign o_job_valid = r2_v;
    assign o_job       = r2_job;

endmodule

### rtl/nsh_mid_q.sv
module nsh_mid_q (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr,
    input  nsh_pkg::t_job i_job,
    output logic          o_ready,
    output logic          o_valid,
    output nsh_pkg::t_job o_job,
    input  logic          i_rd
);

    localparam int PW = $clog2(nsh_pkg::MID_DEPTH);

    nsh_pkg::t_job r_mem [nsh_pkg::MID_DEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [PW:0]   r_cnt;
    logic          wr_ok;
    logic          rd_ok;

    assign o_ready = r_cnt != (PW+1)'(nsh_pkg::MID_DEPTH);
    assign o_valid = r_cnt != '0;
    assign wr_ok   = i_wr && o_ready;
    assign rd_ok   = i_rd && o_valid;
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_ok) begin
                r_wp <= r_wp + 1'b1;
            end
            if (rd_ok) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (PW+1)'(wr_ok) - (PW+1)'(rd_ok);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            r_mem[r_wp] <= i_job;
        end
    end

endmodule

### rtl/nsh_back.sv
module nsh_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  nsh_pkg::t_cfg i_cfg,
    input  logic          i_job_valid,
    input  nsh_pkg::t_job i_job,
    output logic          o_job_ready,
    input  logic          i_pop,
    output logic          o_empty,
    output nsh_pkg::t_out o_out
);

    localparam int NST = nsh_pkg::Q_BITS + 1;
    localparam int OPW = $clog2(nsh_pkg::OUT_DEPTH);

    function automatic nsh_pkg::t_axis div_step(input nsh_pkg::t_axis a, input int b);
        nsh_pkg::t_axis       r;
        logic [nsh_pkg::NUM_W-1:0] trial;
        r     = a;
        trial = nsh_pkg::NUM_W'(a.den) << b;
        if (!a.direct && a.num >= trial) begin
            r.num    = a.num - trial;
            r.quo[b] = 1'b1;
        end
        return r;
    endfunction

    function automatic nsh_pkg::t_job div_job(input nsh_pkg::t_job j, input int b);
        nsh_pkg::t_job r;
        r    = j;
        r.ax = div_step(j.ax, b);
        r.ay = div_step(j.ay, b);
        return r;
    endfunction

    function automatic logic [6:0] fin(input nsh_pkg::t_axis a, input logic [7:0] mdim);
        logic [8:0] p;
        logic [8:0] top;
        p   = a.direct ? a.val : 9'(a.quo) + a.val;
        top = 9'(mdim) - 9'd1;
        if (p > top) begin
            p = top;
        end
        return p[6:0];
    endfunction

    logic          r_dv [NST];
    nsh_pkg::t_job r_dj [NST];

    logic          r_cv;
    nsh_pkg::t_job r_cj;
    logic [6:0]    r_col;
    logic [6:0]    r_row;

    logic          r_xv;
    nsh_pkg::t_job r_xj;
    logic [6:0]    r_xcol;
    logic [6:0]    r_xrow;
    logic [nsh_pkg::ADDR_W-1:0] r_idx;

    logic [31:0]   r_tex [nsh_pkg::TEXEL_COUNT];
    logic          r_mv;
    logic [31:0]   r_rd;
    logic [1:0]    r_mstat;
    logic [6:0]    r_mcol;
    logic [6:0]    r_mrow;

    nsh_pkg::t_out r_of [nsh_pkg::OUT_DEPTH];
    logic [OPW-1:0] r_owp;
    logic [OPW-1:0] r_orp;
    logic [OPW:0]   r_ocnt;
    logic [OPW:0]   r_pend;

    logic          issue;
    logic          pop_ok;
    logic [7:0]    chan;
    nsh_pkg::t_out res;
    logic [14:0]   idx_full;

    assign o_job_ready = r_pend < (OPW+1)'(nsh_pkg::OUT_DEPTH);
    assign issue       = i_job_valid && o_job_ready;
    assign o_empty     = r_ocnt == '0;
    assign pop_ok      = i_pop && !o_empty;
    assign o_out       = r_of[r_orp];
    assign idx_full    = 15'(r_row) * 15'(i_cfg.mask_width) + 15'(r_col);

    always_comb begin
        chan = r_rd[8*i_cfg.channel_select +: 8];
        res  = '0;
        res.status = r_mstat;
        if (r_mstat == nsh_pkg::ST_SAMPLED) begin
            res.hit           = $signed({2'b00, chan}) >
                                $signed({i_cfg.threshold[8], i_cfg.threshold});
            res.sample_column = r_mcol;
            res.sample_row    = r_mrow;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv[0] <= 1'b0;
        end else begin
            r_dv[0] <= issue;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dj[0] <= i_job;
    end

    for (genvar g = 0; g < NST - 1; g++) begin : g_div
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[g+1] <= 1'b0;
            end else begin
                r_dv[g+1] <= r_dv[g];
            end
        end
        always_ff @(posedge i_clk) begin
            r_dj[g+1] <= div_job(r_dj[g], nsh_pkg::Q_BITS - 1 - g);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cv   <= 1'b0;
            r_xv   <= 1'b0;
            r_mv   <= 1'b0;
            r_owp  <= '0;
            r_orp  <= '0;
            r_ocnt <= '0;
            r_pend <= '0;
        end else begin
            r_cv <= r_dv[NST-1];
            r_xv <= r_cv;
            r_mv <= r_xv && r_xj.opcode == nsh_pkg::OP_QUERY;
            if (r_mv) begin
                r_owp <= r_owp + 1'b1;
            end
            if (pop_ok) begin
                r_orp <= r_orp + 1'b1;
            end
            r_ocnt <= r_ocnt + (OPW+1)'(r_mv) - (OPW+1)'(pop_ok);
            r_pend <= r_pend + (OPW+1)'(issue && i_job.opcode == nsh_pkg::OP_QUERY)
                      - (OPW+1)'(pop_ok);
        end
    end

    always_ff @(posedge i_clk) begin
        r_cj   <= r_dj[NST-1];
        r_col  <= fin(r_dj[NST-1].ax, i_cfg.mask_width);
        r_row  <= fin(r_dj[NST-1].ay, i_cfg.mask_height);
        r_xj   <= r_cj;
        r_xcol <= r_col;
        r_xrow <= r_row;
        r_idx  <= idx_full[nsh_pkg::ADDR_W-1:0];
        if (r_xv && r_xj.opcode == nsh_pkg::OP_LOAD) begin
            r_tex[r_xj.addr] <= r_xj.data;
        end
        r_rd    <= r_tex[r_idx];
        r_mstat <= r_xj.status;
        r_mcol  <= r_xcol;
        r_mrow  <= r_xrow;
        if (r_mv) begin
            r_of[r_owp] <= res;
        end
    end

endmodule

### rtl/nine_slice_mask_hit_test_core.sv
// Nine-slice picking mask hit test.
// Input queue: drive i_in with push high while full is low. A transaction is
// either a texel load (opcode 0, one 32-bit RGBA texel at texel_index) or a
// pick query (opcode 1, point and sprite corner in 12.4, size in 11.4 fixed point).
// Result queue: while empty is low, o_out holds the oldest result; pop takes
// it. Each query gives one result; a load gives none.
// Configuration: i_cfg_valid with i_cfg_index and i_cfg_data; o_cfg_ready
// is always high. Write only while no transaction is in flight.
// Throughput: one transaction per cycle while full is low. After a query is
// accepted, its result passes two front stages (clamp, region and product),
// the four-entry queue, an input register and seven restoring divider
// stages per axis (one quotient bit each), texel select, index multiply,
// mask memory read, and threshold compare into the result queue.
// When pop stays low, the 16-entry result queue fills; queries are held back
// by credit, then the middle queue and front fill and full rises.
// Reset clears the control state and the registers (channel to alpha); the
// mask memory is not cleared and must be loaded before use.
module nine_slice_mask_hit_test_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          push,
    output logic          full,
    input  nsh_pkg::t_in  i_in,
    output logic          empty,
    input  logic          pop,
    output nsh_pkg::t_out o_out,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [2:0]    i_cfg_index,
    input  logic [8:0]    i_cfg_data
);

    logic [7:0]        r_left;
    logic [7:0]        r_top;
    logic [7:0]        r_right;
    logic [7:0]        r_bottom;
    logic [7:0]        r_mw;
    logic [7:0]        r_mh;
    logic [1:0]        r_chan;
    logic signed [8:0] r_thr;
    nsh_pkg::t_cfg     cfg;

    logic          f_valid;
    nsh_pkg::t_job f_job;
    logic          q_ready;
    logic          q_valid;
    nsh_pkg::t_job q_job;
    logic          b_ready;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left   <= '0;
            r_top    <= '0;
            r_right  <= '0;
            r_bottom <= '0;
            r_mw     <= '0;
            r_mh     <= '0;
            r_chan   <= 2'd3;
            r_thr    <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                nsh_pkg::CFG_LEFT:   r_left   <= i_cfg_data[7:0];
                nsh_pkg::CFG_TOP:    r_top    <= i_cfg_data[7:0];
                nsh_pkg::CFG_RIGHT:  r_right  <= i_cfg_data[7:0];
                nsh_pkg::CFG_BOTTOM: r_bottom <= i_cfg_data[7:0];
                nsh_pkg::CFG_MASK_W: r_mw     <= i_cfg_data[7:0];
                nsh_pkg::CFG_MASK_H: r_mh     <= i_cfg_data[7:0];
                nsh_pkg::CFG_CHAN:   r_chan   <= i_cfg_data[1:0];
                nsh_pkg::CFG_THRESH: r_thr    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        cfg.left_edge      = r_left;
        cfg.top_edge       = r_top;
        cfg.right_edge     = r_right;
        cfg.bottom_edge    = r_bottom;
        cfg.mask_width     = (r_mw > 8'(nsh_pkg::MAX_MASK_DIM)) ?
                             8'(nsh_pkg::MAX_MASK_DIM) : r_mw;
        cfg.mask_height    = (r_mh > 8'(nsh_pkg::MAX_MASK_DIM)) ?
                             8'(nsh_pkg::MAX_MASK_DIM) : r_mh;
        cfg.channel_select = r_chan;
        cfg.threshold      = r_thr;
    end

    nsh_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_push      (push),
        .i_item      (i_in),
        .o_full      (full),
        .o_job_valid (f_valid),
        .o_job       (f_job),
        .i_job_ready (q_ready)
    );

    nsh_mid_q u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (f_valid),
        .i_job   (f_job),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_job   (q_job),
        .i_rd    (b_ready)
    );

    nsh_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_job_valid (q_valid),
        .i_job       (q_job),
        .o_job_ready (b_ready),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_out       (o_out)
    );

endmodule

### rtl/nsh_chk.sv
module nsh_chk (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          push,
    input logic          full,
    input nsh_pkg::t_in  i_in,
    input logic          empty,
    input logic          pop,
    input nsh_pkg::t_out o_out,
    input logic          i_cfg_valid,
    input logic          o_cfg_ready,
    input logic [2:0]    i_cfg_index,
    input logic [8:0]    i_cfg_data
);

    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    a_ready_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !full)
        else $error("input queue full after reset");

    a_no_sample_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_out.status != nsh_pkg::ST_SAMPLED) |->
        (!o_out.hit && o_out.sample_column == 7'd0 && o_out.sample_row == 7'd0))
        else $error("result without sample carries data");

    a_status_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_out.status == nsh_pkg::ST_SAMPLED ||
                    o_out.status == nsh_pkg::ST_NO_MASK ||
                    o_out.status == nsh_pkg::ST_EDGES))
        else $error("illegal status code");

endmodule

bind nine_slice_mask_hit_test_core nsh_chk u_chk (.*);
